@@ sv/assert_macros.svh @@
// Assertion macros shared by the calibrator RTL.
// No dependencies; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IMUC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define IMUC_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define IMUC_ASSERT(lbl, clk, rstn, prop, msg)
`define IMUC_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

@@ sv/imuc_pkg.sv @@
// Types, constants and register codes of the IMU offset calibrator.
// No dependencies; used by every module of the block.
`default_nettype none
package imuc_pkg;

	localparam int NUM_AXES        = 6;
	localparam int DATA_W          = 16;
	localparam int ACCEL_SHIFT_DEF = 5;
	localparam int GYRO_SHIFT_DEF  = 3;
	localparam int AXIS_AZ         = 2;

	typedef logic [DATA_W-1:0] word_t;

	localparam word_t PERIOD_RESET   = 16'd100;
	localparam word_t ZTARGET_RESET  = 16'd16384;
	localparam word_t OFFSET_RESET   = 16'd0;
	localparam word_t OFFSET_MIN     = 16'h8000;
	localparam word_t OFFSET_MAX     = 16'h7fff;

	typedef enum logic [2:0] {
		REG_ADJUST_PERIOD    = 3'd0,
		REG_Z_GRAVITY_TARGET = 3'd1,
		REG_INIT_AX          = 3'd2,
		REG_INIT_AY          = 3'd3,
		REG_INIT_AZ          = 3'd4,
		REG_INIT_GX          = 3'd5,
		REG_INIT_GY          = 3'd6,
		REG_INIT_GZ          = 3'd7
	} reg_idx_t;

	localparam reg_idx_t INIT_REG [NUM_AXES] = '{
		REG_INIT_AX, REG_INIT_AY, REG_INIT_AZ, REG_INIT_GX, REG_INIT_GY, REG_INIT_GZ
	};

	// Per-lane control from the top level.
	typedef struct packed {
		logic advance;
		logic trigger;
		logic load;
	} lane_ctrl_t;

	// One result transaction.
	typedef struct packed {
		word_t [NUM_AXES-1:0] offset;
		logic                 updated;
	} res_t;

endpackage
`default_nettype wire

@@ sv/imuc_lane.sv @@
// One axis lane: leaky accumulator, average and saturating offset step.
// Depends on imuc_pkg.
`default_nettype none
module imuc_lane #(
	parameter int SHIFT = imuc_pkg::ACCEL_SHIFT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire imuc_pkg::lane_ctrl_t ctrl,
	input  wire logic signed [15:0]  load_value,
	input  wire logic signed [15:0]  sample,
	input  wire logic signed [15:0]  target,
	output logic signed [15:0]       offset_nxt
);

	localparam int AW = imuc_pkg::DATA_W + SHIFT;

	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] sample_ext;
	logic signed [AW-1:0] acc_nxt;
	logic signed [15:0]   avg;
	logic signed [15:0]   offset_q;
	logic signed [15:0]   offset_step;

	assign sample_ext = {{SHIFT{sample[15]}}, sample};
	assign acc_nxt    = acc_q - (acc_q >>> SHIFT) + sample_ext;
	// The upper bits of the accumulator are its floor-shifted average.
	assign avg        = acc_nxt[AW-1:SHIFT];

	always_comb begin
		if (avg > target) begin
			offset_step = (offset_q != imuc_pkg::OFFSET_MIN) ? offset_q - 16'sd1 : offset_q;
		end else begin
			offset_step = (offset_q != imuc_pkg::OFFSET_MAX) ? offset_q + 16'sd1 : offset_q;
		end
	end

	assign offset_nxt = (ctrl.advance && ctrl.trigger) ? offset_step : offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			offset_q <= imuc_pkg::OFFSET_RESET;
		end else begin
			if (ctrl.advance) begin
				acc_q <= acc_nxt;
			end
			if (ctrl.load) begin
				offset_q <= load_value;
			end else begin
				offset_q <= offset_nxt;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/imuc_outbuf.sv @@
// Two-entry output buffer that holds the merged lane results as one transaction
// and decouples the output stall from the input. Depends on imuc_pkg.
`default_nettype none
`include "assert_macros.svh"
module imuc_outbuf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire imuc_pkg::res_t push_data,
	output logic                full,
	output logic                out_valid,
	input  wire logic           out_stall,
	output imuc_pkg::res_t      out_data
);

	logic           main_valid_q;
	logic           skid_valid_q;
	imuc_pkg::res_t main_q;
	imuc_pkg::res_t skid_q;
	logic           pop;

	assign pop       = main_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= push;
				end else begin
					main_valid_q <= push;
				end
			end else if (!main_valid_q) begin
				main_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end else if (!main_valid_q) begin
			main_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	`IMUC_ASSERT(a_skid_behind_main, clk, arst_n, !skid_valid_q || main_valid_q, "skid entry without head entry")
	`IMUC_ASSERT_NEXT(a_head_held, clk, arst_n, main_valid_q && out_stall, main_valid_q && $stable(main_q), "stalled head entry lost")
	`IMUC_ASSERT_NEXT(a_skid_moves_up, clk, arst_n, pop && skid_valid_q, main_valid_q && main_q == $past(skid_q), "skid entry not moved to head")

endmodule
`default_nettype wire

@@ sv/imu_offset_auto_calibrator.sv @@
// IMU offset auto-calibrator. Six lanes, one per axis, each run a leaky
// accumulator and step their offset towards a zero average (the z
// accelerometer axis towards the 1g target) every adjust_period samples.
// A sample is accepted every clock cycle while the output buffer is not full;
// its result is registered in the output buffer, and the two-entry buffer
// keeps taking samples while one result waits under stall. The rate is set
// by the accumulator update of each lane. Writing an initial offset register
// loads that axis offset, taking priority over an offset step. Depends on
// imuc_pkg and imuc_lane, imuc_outbuf.
`default_nettype none
`include "assert_macros.svh"
module imu_offset_auto_calibrator #(
	parameter int ACCEL_SHIFT = imuc_pkg::ACCEL_SHIFT_DEF,
	parameter int GYRO_SHIFT  = imuc_pkg::GYRO_SHIFT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] gyro_x,
	input  wire logic signed [15:0] gyro_y,
	input  wire logic signed [15:0] gyro_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      offset_ax,
	output logic signed [15:0]      offset_ay,
	output logic signed [15:0]      offset_az,
	output logic signed [15:0]      offset_gx,
	output logic signed [15:0]      offset_gy,
	output logic signed [15:0]      offset_gz,
	output logic                    offsets_updated
);

	localparam int N = imuc_pkg::NUM_AXES;

	imuc_pkg::reg_idx_t   reg_idx;
	logic [15:0]          period_q;
	logic signed [15:0]   ztarget_q;
	logic [15:0]          cnt_q;
	logic                 accept;
	logic                 trigger;
	logic                 buf_full;
	logic signed [15:0]   sample [N];
	logic signed [15:0]   target [N];
	logic signed [15:0]   offset_nxt [N];
	imuc_pkg::lane_ctrl_t ctrl [N];
	imuc_pkg::res_t       res;
	imuc_pkg::res_t       out_res;

	assign reg_idx  = imuc_pkg::reg_idx_t'(cfg_index);
	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;
	assign trigger  = (cnt_q == period_q);

	assign sample[0] = accel_x;
	assign sample[1] = accel_y;
	assign sample[2] = accel_z;
	assign sample[3] = gyro_x;
	assign sample[4] = gyro_y;
	assign sample[5] = gyro_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= imuc_pkg::PERIOD_RESET;
			ztarget_q <= imuc_pkg::ZTARGET_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				imuc_pkg::REG_ADJUST_PERIOD:    period_q  <= cfg_data;
				imuc_pkg::REG_Z_GRAVITY_TARGET: ztarget_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The counter restarts at one after a step, since the step sample counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= trigger ? 16'd1 : cnt_q + 16'd1;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_lane
		assign target[i]       = (i == imuc_pkg::AXIS_AZ) ? ztarget_q : 16'sd0;
		assign ctrl[i].advance = accept;
		assign ctrl[i].trigger = trigger;
		assign ctrl[i].load    = cfg_write && (reg_idx == imuc_pkg::INIT_REG[i]);
		assign res.offset[i]   = offset_nxt[i];

		imuc_lane #(
			.SHIFT((i < N / 2) ? ACCEL_SHIFT : GYRO_SHIFT)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl[i]),
			.load_value (cfg_data),
			.sample     (sample[i]),
			.target     (target[i]),
			.offset_nxt (offset_nxt[i])
		);
	end

	assign res.updated = trigger;

	imuc_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign offset_ax       = out_res.offset[0];
	assign offset_ay       = out_res.offset[1];
	assign offset_az       = out_res.offset[2];
	assign offset_gx       = out_res.offset[3];
	assign offset_gy       = out_res.offset[4];
	assign offset_gz       = out_res.offset[5];
	assign offsets_updated = out_res.updated;

	`IMUC_ASSERT_NEXT(a_cnt_restart, clk, arst_n, accept && trigger, cnt_q == 16'd1, "counter not restarted after step")
	`IMUC_ASSERT_NEXT(a_cnt_inc, clk, arst_n, accept && !trigger, cnt_q == $past(cnt_q) + 16'd1, "counter did not advance")
	`IMUC_ASSERT_NEXT(a_cnt_idle, clk, arst_n, !accept, $stable(cnt_q), "counter moved without a transaction")

endmodule
`default_nettype wire
